// File: rtl/lav_pkg.sv
`default_nettype none
package lav_pkg;

    typedef logic [2:0][31:0] vec3_t;
    typedef logic [2:0][63:0] vec64_t;

    // data that rides along the pipeline beside the vector being normalized
    typedef struct packed {
        vec3_t eye;
        vec3_t up;
        vec3_t bk;
        vec3_t sd;
    } side_t;

    typedef struct packed {
        logic signed [31:0] eye_x;
        logic signed [31:0] eye_y;
        logic signed [31:0] eye_z;
        logic signed [31:0] target_x;
        logic signed [31:0] target_y;
        logic signed [31:0] target_z;
        logic signed [31:0] upward_x;
        logic signed [31:0] upward_y;
        logic signed [31:0] upward_z;
    } lav_in_t;

    typedef struct packed {
        logic signed [31:0] side_x;
        logic signed [31:0] side_y;
        logic signed [31:0] side_z;
        logic signed [31:0] camera_up_x;
        logic signed [31:0] camera_up_y;
        logic signed [31:0] camera_up_z;
        logic signed [31:0] back_x;
        logic signed [31:0] back_y;
        logic signed [31:0] back_z;
        logic signed [31:0] shift_0;
        logic signed [31:0] shift_1;
        logic signed [31:0] shift_2;
    } lav_out_t;

    localparam int SQRT_N    = 31;  // root bits, one per stage
    localparam int DIV_N     = 31;  // quotient bits, one per stage
    localparam int UNIT_LAT  = 6 + SQRT_N + 1 + DIV_N + 1;
    localparam int CROSS_LAT = 2;
    localparam int XLATE_LAT = 3;
    localparam int LAT       = 1 + 3 * UNIT_LAT + 2 * CROSS_LAT + XLATE_LAT;

endpackage
`default_nettype wire

// File: rtl/lav_unit.sv
`default_nettype none
module lav_unit
    import lav_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   in_valid,
    input  vec64_t in_vec,
    input  side_t  in_side,
    output logic   out_valid,
    output vec3_t  out_vec,
    output side_t  out_side
);

    // A: sign / magnitude
    logic             a_valid_reg;
    logic [2:0][63:0] a_mag_reg;
    logic [2:0][63:0] a_mag_next;
    logic [2:0]       a_neg_reg;
    side_t            a_side_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            a_mag_next[i] = in_vec[i][63] ? (64'd0 - in_vec[i]) : in_vec[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            a_valid_reg <= 1'b0;
        else
            a_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        a_mag_reg  <= a_mag_next;
        a_side_reg <= in_side;
        for (int i = 0; i < 3; i++)
        begin
            a_neg_reg[i] <= in_vec[i][63];
        end
    end

    // B: leading one within each byte of the OR of magnitudes
    logic             b_valid_reg;
    logic [63:0]      b_or;
    logic [7:0]       b_nz_next;
    logic [7:0]       b_nz_reg;
    logic [7:0][2:0]  b_pos_next;
    logic [7:0][2:0]  b_pos_reg;
    logic [2:0][63:0] b_mag_reg;
    logic [2:0]       b_neg_reg;
    side_t            b_side_reg;

    always_comb
    begin
        b_or = a_mag_reg[0] | a_mag_reg[1] | a_mag_reg[2];
        for (int k = 0; k < 8; k++)
        begin
            b_nz_next[k]  = |b_or[8*k +: 8];
            b_pos_next[k] = 3'd0;
            for (int b = 0; b < 8; b++)
            begin
                if (b_or[8*k + b])
                    b_pos_next[k] = 3'(b);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            b_valid_reg <= 1'b0;
        else
            b_valid_reg <= a_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        b_nz_reg   <= b_nz_next;
        b_pos_reg  <= b_pos_next;
        b_mag_reg  <= a_mag_reg;
        b_neg_reg  <= a_neg_reg;
        b_side_reg <= a_side_reg;
    end

    // C: combine bytes into the leading-one position
    logic             c_valid_reg;
    logic [5:0]       c_pos_next;
    logic [5:0]       c_pos_reg;
    logic             c_zero_reg;
    logic [2:0][63:0] c_mag_reg;
    logic [2:0]       c_neg_reg;
    side_t            c_side_reg;

    always_comb
    begin
        c_pos_next = 6'd0;
        for (int k = 0; k < 8; k++)
        begin
            if (b_nz_reg[k])
                c_pos_next = {3'(k), b_pos_reg[k]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            c_valid_reg <= 1'b0;
        else
            c_valid_reg <= b_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        c_pos_reg  <= c_pos_next;
        c_zero_reg <= ~|b_nz_reg;
        c_mag_reg  <= b_mag_reg;
        c_neg_reg  <= b_neg_reg;
        c_side_reg <= b_side_reg;
    end

    // D: common shift so the largest magnitude sits in [2^29, 2^30)
    logic             d_valid_reg;
    logic [2:0][29:0] d_m_next;
    logic [2:0][29:0] d_m_reg;
    logic [5:0]       d_rsh;
    logic [5:0]       d_lsh;
    logic             d_zero_reg;
    logic [2:0]       d_neg_reg;
    side_t            d_side_reg;

    always_comb
    begin
        d_rsh = c_pos_reg - 6'd29;
        d_lsh = 6'd29 - c_pos_reg;
        for (int i = 0; i < 3; i++)
        begin
            if (c_pos_reg >= 6'd30)
                d_m_next[i] = 30'(c_mag_reg[i] >> d_rsh);
            else
                d_m_next[i] = 30'(c_mag_reg[i] << d_lsh);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            d_valid_reg <= 1'b0;
        else
            d_valid_reg <= c_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        d_m_reg    <= d_m_next;
        d_zero_reg <= c_zero_reg;
        d_neg_reg  <= c_neg_reg;
        d_side_reg <= c_side_reg;
    end

    // E: squares
    logic             e_valid_reg;
    logic [2:0][59:0] e_sq_reg;
    logic [2:0][29:0] e_m_reg;
    logic             e_zero_reg;
    logic [2:0]       e_neg_reg;
    side_t            e_side_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            e_valid_reg <= 1'b0;
        else
            e_valid_reg <= d_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            e_sq_reg[i] <= d_m_reg[i] * d_m_reg[i];
        end
        e_m_reg    <= d_m_reg;
        e_zero_reg <= d_zero_reg;
        e_neg_reg  <= d_neg_reg;
        e_side_reg <= d_side_reg;
    end

    // F + square root: entry 0 holds the sum of squares
    logic             sq_valid [0:SQRT_N];
    logic [61:0]      sq_rem  [0:SQRT_N];
    logic [30:0]      sq_root [0:SQRT_N];
    logic [2:0][29:0] sq_m    [0:SQRT_N];
    logic [2:0]       sq_neg  [0:SQRT_N];
    logic             sq_zero [0:SQRT_N];
    side_t            sq_side [0:SQRT_N];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sq_valid[0] <= 1'b0;
        else
            sq_valid[0] <= e_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        sq_rem[0]  <= 62'(e_sq_reg[0]) + 62'(e_sq_reg[1]) + 62'(e_sq_reg[2]);
        sq_root[0] <= 31'd0;
        sq_m[0]    <= e_m_reg;
        sq_neg[0]  <= e_neg_reg;
        sq_zero[0] <= e_zero_reg;
        sq_side[0] <= e_side_reg;
    end

    for (genvar k = 0; k < SQRT_N; k++)
    begin : g_sqrt
        localparam int B = SQRT_N - 1 - k;
        logic [63:0] trial;
        logic        take;

        assign trial = ({33'd0, sq_root[k]} << (B + 1)) | (64'd1 << (2 * B));
        assign take  = {2'b00, sq_rem[k]} >= trial;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                sq_valid[k+1] <= 1'b0;
            else
                sq_valid[k+1] <= sq_valid[k];
        end

        always_ff @(posedge clk)
        begin
            sq_rem[k+1]  <= take ? (sq_rem[k] - trial[61:0]) : sq_rem[k];
            sq_root[k+1] <= take ? (sq_root[k] | (31'd1 << B)) : sq_root[k];
            sq_m[k+1]    <= sq_m[k];
            sq_neg[k+1]  <= sq_neg[k];
            sq_zero[k+1] <= sq_zero[k];
            sq_side[k+1] <= sq_side[k];
        end
    end

    // divide: entry 0 holds rounded numerators mag*2^30 + len/2
    logic             dv_valid [0:DIV_N];
    logic [2:0][60:0] dv_rem [0:DIV_N];
    logic [2:0][30:0] dv_q   [0:DIV_N];
    logic [30:0]      dv_len [0:DIV_N];
    logic [2:0]       dv_neg [0:DIV_N];
    logic             dv_zero [0:DIV_N];
    side_t            dv_side [0:DIV_N];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dv_valid[0] <= 1'b0;
        else
            dv_valid[0] <= sq_valid[SQRT_N];
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            dv_rem[0][i] <= {1'b0, sq_m[SQRT_N][i], 30'd0} + 61'(sq_root[SQRT_N] >> 1);
            dv_q[0][i]   <= 31'd0;
        end
        dv_len[0]  <= sq_root[SQRT_N];
        dv_neg[0]  <= sq_neg[SQRT_N];
        dv_zero[0] <= sq_zero[SQRT_N];
        dv_side[0] <= sq_side[SQRT_N];
    end

    for (genvar k = 0; k < DIV_N; k++)
    begin : g_div
        localparam int B = DIV_N - 1 - k;
        logic [61:0]      dvs;
        logic [2:0][60:0] rem_next;
        logic [2:0][30:0] q_next;

        assign dvs = 62'(dv_len[k]) << B;

        always_comb
        begin
            for (int i = 0; i < 3; i++)
            begin
                if ({1'b0, dv_rem[k][i]} >= dvs)
                begin
                    rem_next[i] = dv_rem[k][i] - dvs[60:0];
                    q_next[i]   = dv_q[k][i] | (31'd1 << B);
                end
                else
                begin
                    rem_next[i] = dv_rem[k][i];
                    q_next[i]   = dv_q[k][i];
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                dv_valid[k+1] <= 1'b0;
            else
                dv_valid[k+1] <= dv_valid[k];
        end

        always_ff @(posedge clk)
        begin
            dv_rem[k+1]  <= rem_next;
            dv_q[k+1]    <= q_next;
            dv_len[k+1]  <= dv_len[k];
            dv_neg[k+1]  <= dv_neg[k];
            dv_zero[k+1] <= dv_zero[k];
            dv_side[k+1] <= dv_side[k];
        end
    end

    // sign and zero-vector fixup
    logic  o_valid_reg;
    vec3_t o_vec_reg;
    vec3_t o_vec_next;
    side_t o_side_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (dv_zero[DIV_N])
                o_vec_next[i] = 32'd0;
            else if (dv_neg[DIV_N][i])
                o_vec_next[i] = 32'd0 - {1'b0, dv_q[DIV_N][i]};
            else
                o_vec_next[i] = {1'b0, dv_q[DIV_N][i]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            o_valid_reg <= 1'b0;
        else
            o_valid_reg <= dv_valid[DIV_N];
    end

    always_ff @(posedge clk)
    begin
        o_vec_reg  <= o_vec_next;
        o_side_reg <= dv_side[DIV_N];
    end

    assign out_valid = o_valid_reg;
    assign out_vec   = o_vec_reg;
    assign out_side  = o_side_reg;

endmodule
`default_nettype wire

// File: rtl/lav_cross.sv
`default_nettype none
module lav_cross
    import lav_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   in_valid,
    input  vec3_t  a,
    input  vec3_t  b,
    input  side_t  in_side,
    output logic   out_valid,
    output vec64_t out_vec,
    output side_t  out_side
);

    logic             p_valid_reg;
    logic [5:0][63:0] p_reg;
    side_t            p_side_reg;
    logic             x_valid_reg;
    vec64_t           x_reg;
    side_t            x_side_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_valid_reg <= 1'b0;
            x_valid_reg <= 1'b0;
        end
        else
        begin
            p_valid_reg <= in_valid;
            x_valid_reg <= p_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        p_reg[0]   <= $signed(a[1]) * $signed(b[2]);
        p_reg[1]   <= $signed(a[2]) * $signed(b[1]);
        p_reg[2]   <= $signed(a[2]) * $signed(b[0]);
        p_reg[3]   <= $signed(a[0]) * $signed(b[2]);
        p_reg[4]   <= $signed(a[0]) * $signed(b[1]);
        p_reg[5]   <= $signed(a[1]) * $signed(b[0]);
        p_side_reg <= in_side;
        x_reg[0]   <= p_reg[0] - p_reg[1];
        x_reg[1]   <= p_reg[2] - p_reg[3];
        x_reg[2]   <= p_reg[4] - p_reg[5];
        x_side_reg <= p_side_reg;
    end

    assign out_valid = x_valid_reg;
    assign out_vec   = x_reg;
    assign out_side  = x_side_reg;

endmodule
`default_nettype wire

// File: rtl/lav_xlate.sv
`default_nettype none
module lav_xlate
    import lav_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    input  vec3_t    cu,
    input  side_t    in_side,
    output logic     out_valid,
    output lav_out_t out_res
);

    // rows: 0 side, 1 up, 2 back
    logic                  p_valid_reg;
    logic [2:0][2:0][63:0] p_reg;
    vec3_t                 p_sd_reg;
    vec3_t                 p_cu_reg;
    vec3_t                 p_bk_reg;

    logic                  s_valid_reg;
    logic signed [65:0]    s_acc_reg [0:2];
    vec3_t                 s_sd_reg;
    vec3_t                 s_cu_reg;
    vec3_t                 s_bk_reg;

    logic                  o_valid_reg;
    lav_out_t              o_res_reg;
    logic [2:0][31:0]      o_sh_next;
    logic signed [35:0]    o_r;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_valid_reg <= 1'b0;
            s_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end
        else
        begin
            p_valid_reg <= in_valid;
            s_valid_reg <= p_valid_reg;
            o_valid_reg <= s_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int j = 0; j < 3; j++)
        begin
            p_reg[0][j] <= $signed(in_side.sd[j]) * $signed(in_side.eye[j]);
            p_reg[1][j] <= $signed(cu[j]) * $signed(in_side.eye[j]);
            p_reg[2][j] <= $signed(in_side.bk[j]) * $signed(in_side.eye[j]);
        end
        p_sd_reg <= in_side.sd;
        p_cu_reg <= cu;
        p_bk_reg <= in_side.bk;
    end

    // round to Q16.16: negate, add half an LSB, floor
    always_ff @(posedge clk)
    begin
        for (int r = 0; r < 3; r++)
        begin
            s_acc_reg[r] <= 66'sd536870912
                          - ($signed(p_reg[r][0]) + $signed(p_reg[r][1])
                             + $signed(p_reg[r][2]));
        end
        s_sd_reg <= p_sd_reg;
        s_cu_reg <= p_cu_reg;
        s_bk_reg <= p_bk_reg;
    end

    always_comb
    begin
        o_r = '0;
        for (int r = 0; r < 3; r++)
        begin
            o_r = 36'(s_acc_reg[r] >>> 30);
            if (o_r > 36'sd2147483647)
                o_sh_next[r] = 32'h7fff_ffff;
            else if (o_r < -36'sd2147483648)
                o_sh_next[r] = 32'h8000_0000;
            else
                o_sh_next[r] = o_r[31:0];
        end
    end

    always_ff @(posedge clk)
    begin
        o_res_reg.side_x      <= s_sd_reg[0];
        o_res_reg.side_y      <= s_sd_reg[1];
        o_res_reg.side_z      <= s_sd_reg[2];
        o_res_reg.camera_up_x <= s_cu_reg[0];
        o_res_reg.camera_up_y <= s_cu_reg[1];
        o_res_reg.camera_up_z <= s_cu_reg[2];
        o_res_reg.back_x      <= s_bk_reg[0];
        o_res_reg.back_y      <= s_bk_reg[1];
        o_res_reg.back_z      <= s_bk_reg[2];
        o_res_reg.shift_0     <= o_sh_next[0];
        o_res_reg.shift_1     <= o_sh_next[1];
        o_res_reg.shift_2     <= o_sh_next[2];
    end

    assign out_valid = o_valid_reg;
    assign out_res   = o_res_reg;

endmodule
`default_nettype wire

// File: rtl/look_at_view_matrix.sv
// Look-at view transform. Raise start with eye, target and up vectors (signed
// Q16.16) on params; busy is always low, so an item is taken on every cycle
// start is high, back to back. The 3x3 rotation (rows side, camera up, back;
// signed Q2.30, unit length, all zero for a degenerate axis) and the
// translation column (minus row dot eye, rounded and saturated to Q16.16)
// appear on result for exactly one cycle with done high, in order. The
// receiver cannot stall, so there is no backpressure and nothing is ever
// held or dropped. The latency is mostly set by the three normalizers in
// series: each spends 31 stages on a bit-per-stage square root and 31 on
// bit-per-stage division, plus 8 setup stages.
`default_nettype none
module look_at_view_matrix
    import lav_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    output logic     busy,
    input  lav_in_t  params,
    output logic     done,
    output lav_out_t result
);

    // front stage: backward axis before normalizing is eye - target
    logic   f_valid_reg;
    vec64_t f_raw_reg;
    side_t  f_side_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            f_valid_reg <= 1'b0;
        else
            f_valid_reg <= start;
    end

    always_ff @(posedge clk)
    begin
        f_raw_reg[0]   <= 64'(params.eye_x) - 64'(params.target_x);
        f_raw_reg[1]   <= 64'(params.eye_y) - 64'(params.target_y);
        f_raw_reg[2]   <= 64'(params.eye_z) - 64'(params.target_z);
        f_side_reg.eye <= {params.eye_z, params.eye_y, params.eye_x};
        f_side_reg.up  <= {params.upward_z, params.upward_y, params.upward_x};
        f_side_reg.bk  <= '0;
        f_side_reg.sd  <= '0;
    end

    // back axis
    logic   u1_valid;
    vec3_t  u1_vec;
    side_t  u1_side;
    side_t  c1_in_side;

    lav_unit u_unit_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (f_valid_reg),
        .in_vec    (f_raw_reg),
        .in_side   (f_side_reg),
        .out_valid (u1_valid),
        .out_vec   (u1_vec),
        .out_side  (u1_side)
    );

    always_comb
    begin
        c1_in_side    = u1_side;
        c1_in_side.bk = u1_vec;
    end

    // side axis = up x back
    logic   c1_valid;
    vec64_t c1_vec;
    side_t  c1_side;

    lav_cross u_cross_side (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (u1_valid),
        .a         (u1_side.up),
        .b         (u1_vec),
        .in_side   (c1_in_side),
        .out_valid (c1_valid),
        .out_vec   (c1_vec),
        .out_side  (c1_side)
    );

    logic   u2_valid;
    vec3_t  u2_vec;
    side_t  u2_side;
    side_t  c2_in_side;

    lav_unit u_unit_side (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (c1_valid),
        .in_vec    (c1_vec),
        .in_side   (c1_side),
        .out_valid (u2_valid),
        .out_vec   (u2_vec),
        .out_side  (u2_side)
    );

    always_comb
    begin
        c2_in_side    = u2_side;
        c2_in_side.sd = u2_vec;
    end

    // camera up axis = back x side
    logic   c2_valid;
    vec64_t c2_vec;
    side_t  c2_side;

    lav_cross u_cross_up (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (u2_valid),
        .a         (u2_side.bk),
        .b         (u2_vec),
        .in_side   (c2_in_side),
        .out_valid (c2_valid),
        .out_vec   (c2_vec),
        .out_side  (c2_side)
    );

    logic   u3_valid;
    vec3_t  u3_vec;
    side_t  u3_side;

    lav_unit u_unit_up (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (c2_valid),
        .in_vec    (c2_vec),
        .in_side   (c2_side),
        .out_valid (u3_valid),
        .out_vec   (u3_vec),
        .out_side  (u3_side)
    );

    // translation column and output register
    lav_xlate u_xlate (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (u3_valid),
        .cu        (u3_vec),
        .in_side   (u3_side),
        .out_valid (done),
        .out_res   (result)
    );

    // fully pipelined, never refuses an item
    assign busy = 1'b0;

endmodule
`default_nettype wire

// File: rtl/lav_check.sv
`default_nettype none
module lav_check
    import lav_pkg::*;
(
    input logic     clk,
    input logic     rst_n,
    input logic     start,
    input logic     busy,
    input lav_in_t  params,
    input logic     done,
    input lav_out_t result
);

    // every accepted item comes out after the fixed latency
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |-> ##LAT done)
        else $error("item did not complete after pipeline latency");

    // no result without a matching earlier start
    a_source: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, LAT))
        else $error("result with no matching item");

    // diagonal rotation entries are unit-bounded
    a_unit_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.side_x >= -32'sd1073741824 && result.side_x <= 32'sd1073741824
              && result.camera_up_y >= -32'sd1073741824
              && result.camera_up_y <= 32'sd1073741824
              && result.back_z >= -32'sd1073741824 && result.back_z <= 32'sd1073741824))
        else $error("rotation entry out of unit range");

    // eye on the target gives a zero back axis
    a_zero_back: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && params.eye_x == params.target_x
        && params.eye_y == params.target_y && params.eye_z == params.target_z
        |-> ##LAT (result.back_x == 0 && result.back_y == 0 && result.back_z == 0))
        else $error("degenerate back axis not zero");

endmodule

bind look_at_view_matrix lav_check u_lav_check (.*);
`default_nettype wire

// File: sim/lav_checker.sv
module lav_checker
    import lav_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    input  logic     busy,
    input  lav_in_t  params,
    input  logic     done,
    input  lav_out_t result,
    output int       errors,
    output int       pending,
    output int       matrices_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef logic signed [63:0] s64_t;

    lav_out_t expected_views[$];

    function automatic logic [63:0] int_sqrt(input logic [63:0] v);
        logic [63:0] res;
        logic [63:0] bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (v >= res + bitv)
            begin
                v = v - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
                res = res >> 1;
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // scale to a common exponent, then round(mag * 2^30 / len)
    function automatic void normalize(input s64_t vin[3], output s64_t vout[3]);
        logic [63:0] mag[3];
        logic        neg[3];
        logic [63:0] mx, sum, len, q;
        int          rs, ls;
        mx = 0; sum = 0; rs = 0; ls = 0;
        for (int i = 0; i < 3; i++)
        begin
            neg[i] = vin[i] < 0;
            mag[i] = neg[i] ? -vin[i] : vin[i];
            if (mag[i] > mx) mx = mag[i];
        end
        if (mx == 0)
        begin
            for (int i = 0; i < 3; i++) vout[i] = 0;
            return;
        end
        while (mx >= (64'd1 << 30)) begin mx = mx >> 1; rs++; end
        while (mx < (64'd1 << 29)) begin mx = mx << 1; ls++; end
        for (int i = 0; i < 3; i++)
        begin
            mag[i] = (mag[i] >> rs) << ls;
            sum = sum + mag[i] * mag[i];
        end
        len = int_sqrt(sum);
        for (int i = 0; i < 3; i++)
        begin
            q = ((mag[i] << 30) + (len >> 1)) / len;
            vout[i] = neg[i] ? -s64_t'(q) : s64_t'(q);
        end
    endfunction

    // -(row . eye) in Q18.46, round half up to Q16.16, saturate
    function automatic logic [31:0] shift_of(input s64_t row[3], input s64_t eye[3]);
        s64_t acc, r;
        acc = -(row[0] * eye[0] + row[1] * eye[1] + row[2] * eye[2]);
        acc = acc + (s64_t'(1) <<< 29);
        r = acc >>> 30;
        if (r > 64'sd2147483647) r = 64'sd2147483647;
        if (r < -64'sd2147483648) r = -64'sd2147483648;
        return r[31:0];
    endfunction

    function automatic lav_out_t view_of(input lav_in_t p);
        s64_t eye[3], tgt[3], up[3], raw[3], bk[3], sd[3], cu[3];
        lav_out_t o;
        eye = '{s64_t'(p.eye_x), s64_t'(p.eye_y), s64_t'(p.eye_z)};
        tgt = '{s64_t'(p.target_x), s64_t'(p.target_y), s64_t'(p.target_z)};
        up  = '{s64_t'(p.upward_x), s64_t'(p.upward_y), s64_t'(p.upward_z)};
        for (int i = 0; i < 3; i++) raw[i] = eye[i] - tgt[i];
        normalize(raw, bk);
        raw[0] = up[1] * bk[2] - up[2] * bk[1];
        raw[1] = up[2] * bk[0] - up[0] * bk[2];
        raw[2] = up[0] * bk[1] - up[1] * bk[0];
        normalize(raw, sd);
        raw[0] = bk[1] * sd[2] - bk[2] * sd[1];
        raw[1] = bk[2] * sd[0] - bk[0] * sd[2];
        raw[2] = bk[0] * sd[1] - bk[1] * sd[0];
        normalize(raw, cu);
        o.side_x = sd[0][31:0]; o.side_y = sd[1][31:0]; o.side_z = sd[2][31:0];
        o.camera_up_x = cu[0][31:0]; o.camera_up_y = cu[1][31:0];
        o.camera_up_z = cu[2][31:0];
        o.back_x = bk[0][31:0]; o.back_y = bk[1][31:0]; o.back_z = bk[2][31:0];
        o.shift_0 = shift_of(sd, eye);
        o.shift_1 = shift_of(cu, eye);
        o.shift_2 = shift_of(bk, eye);
        return o;
    endfunction

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("%0t: %s got %h want %h", $realtime, what, got, want);
        errors++;
    endtask

    task automatic compare_view(input lav_out_t got, input lav_out_t want);
        if (got.side_x !== want.side_x) report("side_x", got.side_x, want.side_x);
        if (got.side_y !== want.side_y) report("side_y", got.side_y, want.side_y);
        if (got.side_z !== want.side_z) report("side_z", got.side_z, want.side_z);
        if (got.camera_up_x !== want.camera_up_x)
            report("camera_up_x", got.camera_up_x, want.camera_up_x);
        if (got.camera_up_y !== want.camera_up_y)
            report("camera_up_y", got.camera_up_y, want.camera_up_y);
        if (got.camera_up_z !== want.camera_up_z)
            report("camera_up_z", got.camera_up_z, want.camera_up_z);
        if (got.back_x !== want.back_x) report("back_x", got.back_x, want.back_x);
        if (got.back_y !== want.back_y) report("back_y", got.back_y, want.back_y);
        if (got.back_z !== want.back_z) report("back_z", got.back_z, want.back_z);
        if (got.shift_0 !== want.shift_0) report("shift_0", got.shift_0, want.shift_0);
        if (got.shift_1 !== want.shift_1) report("shift_1", got.shift_1, want.shift_1);
        if (got.shift_2 !== want.shift_2) report("shift_2", got.shift_2, want.shift_2);
    endtask

    initial
    begin
        errors = 0;
        pending = 0;
        matrices_seen = 0;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done === 1'b1)
            begin
                matrices_seen++;
                if (expected_views.size() == 0)
                    report("unexpected result", 32'h0, 32'h0);
                else
                    compare_view(result, expected_views.pop_front());
            end
            else if (done !== 1'b0)
                report("done unknown", 32'h0, 32'h0);
            if (start && busy === 1'b0)
                expected_views.push_back(view_of(params));
            pending = expected_views.size();
        end
    end
endmodule

// File: sim/testbench.sv
module testbench
    import lav_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int  RANDOM_ITEMS = 800;
    localparam int  CYCLE_LIMIT  = 200000;  // ~800 items plus the pipeline latency, many times over
    localparam logic [31:0] MAX_POS = 32'h7fff_ffff;
    localparam logic [31:0] MAX_NEG = 32'h8000_0000;
    localparam logic [31:0] ONE     = 32'h0001_0000;

    logic     clk;
    logic     rst_n;
    logic     start;
    logic     busy;
    lav_in_t  params;
    logic     done;
    lav_out_t result;
    int       errors, pending, matrices_seen;
    int       cycles;
    int       sender_idle_pct;
    int       items_sent;

    look_at_view_matrix i_dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .params(params), .done(done), .result(result)
    );

    lav_checker i_checker (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .params(params),
        .done(done), .result(result), .errors(errors), .pending(pending),
        .matrices_seen(matrices_seen)
    );

    always
    begin
        clk = 1'b0; #10;
        clk = 1'b1; #10;
    end

    // watchdog: a hung pipeline ends the run as a failure
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("look_at_view_matrix: mismatch");
            $finish;
        end
    end

    // fields: wide random, small near-unit values, or an extreme
    function automatic logic [31:0] pick_coord();
        case ($urandom_range(0, 5))
            0: return $urandom();
            1: return $urandom_range(0, 1) ? MAX_POS : MAX_NEG;
            2: return 32'($signed($urandom_range(0, 2 * 32'h0004_0000)) - 32'sh0004_0000);
            3: return 32'($signed($urandom_range(0, 2000)) - 1000);
            default: return 32'($signed($urandom_range(0, 2 * 32'h0100_0000)) - 32'sh0100_0000);
        endcase
    endfunction

    // send one item: optional idle cycles, then hold start until taken
    task automatic send(input lav_in_t p);
        while ($urandom_range(0, 99) < sender_idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start  <= 1'b1;
        params <= p;
        @(posedge clk);
        while (busy) @(posedge clk);
        items_sent++;
    endtask

    task automatic send_vecs(input logic [31:0] ex, ey, ez, tx, ty, tz, ux, uy, uz);
        lav_in_t p;
        p = '{ex, ey, ez, tx, ty, tz, ux, uy, uz};
        send(p);
    endtask

    task automatic send_random();
        lav_in_t p;
        p.eye_x = pick_coord(); p.eye_y = pick_coord(); p.eye_z = pick_coord();
        p.upward_x = pick_coord(); p.upward_y = pick_coord(); p.upward_z = pick_coord();
        // now and then the target equals the eye (zero back axis) or
        // up is parallel to back (zero side axis)
        if ($urandom_range(0, 19) == 0)
        begin
            p.target_x = p.eye_x; p.target_y = p.eye_y; p.target_z = p.eye_z;
        end
        else
        begin
            p.target_x = pick_coord(); p.target_y = pick_coord(); p.target_z = pick_coord();
        end
        if ($urandom_range(0, 19) == 0)
        begin
            p.upward_x = p.eye_x - p.target_x;
            p.upward_y = p.eye_y - p.target_y;
            p.upward_z = p.eye_z - p.target_z;
        end
        send(p);
    endtask

    task automatic idle_until_drained();
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    initial
    begin
        cycles = 0;
        items_sent = 0;
        sender_idle_pct = 0;
        rst_n = 1'b0;
        start = 1'b0;
        params = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: canonical view, degenerate axes, extremes
        send_vecs(0, 0, 5 * ONE, 0, 0, 0, 0, ONE, 0);
        send_vecs(0, 0, 0, 0, 0, 0, 0, ONE, 0);              // eye == target
        send_vecs(0, 0, ONE, 0, 0, 0, 0, 0, ONE);            // up parallel to back
        send_vecs(ONE, 2 * ONE, 3 * ONE, 0, 0, 0, 0, 0, 0);  // zero up
        send_vecs(MAX_POS, MAX_POS, MAX_POS, MAX_NEG, MAX_NEG, MAX_NEG,
                  MAX_POS, MAX_NEG, MAX_POS);
        send_vecs(MAX_NEG, MAX_NEG, MAX_NEG, MAX_POS, MAX_POS, MAX_POS,
                  MAX_NEG, MAX_POS, MAX_NEG);
        send_vecs(MAX_POS, 0, 0, MAX_NEG, 0, 0, 0, MAX_POS, 0);
        send_vecs(MAX_NEG, MAX_NEG, 0, 0, 0, MAX_POS, MAX_NEG, 0, MAX_POS);
        send_vecs(1, 0, 0, 0, 0, 0, 0, 1, 0);                // tiny back axis
        send_vecs(1, 1, 1, 0, 0, 0, 0, 0, 1);
        send_vecs(32'hffff_ffff, 0, 0, 0, 0, 0, 0, 0, 32'hffff_ffff);
        send_vecs(MAX_POS, MAX_POS, MAX_POS, 0, 0, 0, 1, 0, 0);   // shift saturates
        send_vecs(MAX_NEG, MAX_NEG, MAX_NEG, 0, 0, 0, 0, 1, 0);
        send_vecs(ONE, ONE, 0, 0, 0, 0, 0, 0, ONE);
        send_vecs(32'h5555_5555, 32'haaaa_aaaa, 32'h1234_5678, 32'haaaa_aaaa,
                  32'h5555_5555, 32'hedcb_a987, 32'h5555_5555, 32'haaaa_aaaa, 32'h0f0f_0f0f);
        idle_until_drained();

        // random: sender idle 36%, then 72%, then back to back
        sender_idle_pct = 36;
        repeat (RANDOM_ITEMS / 3) send_random();
        idle_until_drained();   // sender holds off until all results are in
        sender_idle_pct = 72;
        repeat (RANDOM_ITEMS / 3) send_random();
        sender_idle_pct = 0;
        repeat (RANDOM_ITEMS - 2 * (RANDOM_ITEMS / 3)) send_random();
        idle_until_drained();
        repeat (LAT + 20) @(posedge clk);

        $display("Sent %0d view set-ups (directed extremes, degenerate axes, random);",
                 items_sent);
        $display("checked %0d matrices with sender idle at 36%%, 72%% and 0%%.",
                 matrices_seen);
        if (errors == 0 && pending == 0)
            $display("look_at_view_matrix: match");
        else
            $display("look_at_view_matrix: mismatch");
        $finish;
    end
endmodule
